@@ hw/rtl/kss_pkg.sv @@
`timescale 1ns / 1ps

package kss_pkg;

    localparam int KW_COUNT  = 10;
    localparam int WIN_DEPTH = 22;
    localparam int SPAN      = WIN_DEPTH + 1;
    localparam int LEN_W     = 5;
    localparam int CODE_W    = 4;
    localparam int OFFSET_W  = 16;

    typedef logic [SPAN*8-1:0]      kw_text_t;
    typedef logic [WIN_DEPTH*8-1:0] window_t;
    typedef logic [LEN_W-1:0]       kw_len_t;

    typedef enum logic [CODE_W-1:0] {
        KW_ECDH,
        KW_ECDH_RESP,
        KW_PAIR,
        KW_PAIR_RESP,
        KW_AUTHENTICATION,
        KW_AUTHENTICATION_RESP,
        KW_PLAY,
        KW_PLAY_RESP,
        KW_STOP,
        KW_STOP_RESP
    } kw_code_t;

    // right aligned: the final character of each keyword sits in bits 7:0
    localparam kw_text_t KW_TEXT [KW_COUNT] = '{
        "ECDH",
        {"ECDH", "_RESPONSE"},
        "PAIR",
        {"PAIR", "_RESPONSE"},
        "AUTHENTICATION",
        {"AUTHENTICATION", "_RESPONSE"},
        "PLAY",
        {"PLAY", "_RESPONSE"},
        "STOP",
        {"STOP", "_RESPONSE"}
    };

    localparam kw_len_t KW_LEN [KW_COUNT] = '{
        5'd4, 5'd13, 5'd4, 5'd13, 5'd14, 5'd23, 5'd4, 5'd13, 5'd4, 5'd13
    };

    // longest first; keywords of equal length cannot end on the same byte together
    localparam kw_code_t KW_ORDER [KW_COUNT] = '{
        KW_AUTHENTICATION_RESP,
        KW_AUTHENTICATION,
        KW_ECDH_RESP,
        KW_PAIR_RESP,
        KW_PLAY_RESP,
        KW_STOP_RESP,
        KW_ECDH,
        KW_PAIR,
        KW_PLAY,
        KW_STOP
    };

    typedef struct packed {
        logic     hit;
        kw_code_t code;
        kw_len_t  len;
    } kw_match_t;

    typedef struct packed {
        logic                found;
        logic [CODE_W-1:0]   keyword_code;
        logic [OFFSET_W-1:0] end_offset;
    } scan_result_t;

    function automatic kw_text_t kw_mask(input kw_len_t len);
        kw_text_t ones;
        ones = '1;
        return ~(ones << {len, 3'b000});
    endfunction

endpackage

@@ hw/rtl/kss_match.sv @@
`timescale 1ns / 1ps

module kss_match #(
    parameter int POS_W = 16
) (
    input  kss_pkg::kw_text_t  seq,
    input  logic [POS_W-1:0]   position,
    output kss_pkg::kw_match_t match
);
    import kss_pkg::*;

    logic [KW_COUNT-1:0] hit;

    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            hit[k] = ((seq & kw_mask(KW_LEN[k])) == KW_TEXT[k])
                     && (position >= POS_W'(KW_LEN[k] - 5'd1));
        end
    end

    // highest priority entry is applied last
    always_comb
    begin
        match = '{hit: 1'b0, code: KW_ECDH, len: '0};
        for (int j = KW_COUNT - 1; j >= 0; j--)
        begin
            if (hit[KW_ORDER[j]])
            begin
                match.hit  = 1'b1;
                match.code = KW_ORDER[j];
                match.len  = KW_LEN[KW_ORDER[j]];
            end
        end
    end

endmodule

@@ hw/rtl/kss_scan_state.sv @@
`timescale 1ns / 1ps

module kss_scan_state #(
    parameter int MAX_BUFFER_BYTES = 65535,
    parameter int POS_W            = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  logic [7:0]            step_byte,
    input  logic                  step_last,
    output kss_pkg::scan_result_t result
);
    import kss_pkg::*;

    localparam int EXT_W = (POS_W + 1 > OFFSET_W) ? POS_W + 1 : OFFSET_W;
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BUFFER_BYTES);

    window_t           window_reg,      window_next;
    logic [POS_W-1:0]  position_reg,    position_next;
    logic              best_valid_reg,  best_valid_next;
    logic [POS_W-1:0]  best_start_reg,  best_start_next;
    kw_len_t           best_len_reg,    best_len_next;
    kw_code_t          best_code_reg,   best_code_next;

    kw_text_t          seq;
    kw_match_t         match;
    logic              active;
    logic [POS_W-1:0]  new_start;
    logic              take;
    logic              cand_valid;
    logic [POS_W-1:0]  cand_start;
    kw_len_t           cand_len;
    kw_code_t          cand_code;
    logic [EXT_W-1:0]  end_ext;

    assign seq = {window_reg, step_byte};

    kss_match #(
        .POS_W (POS_W)
    ) u_match (
        .seq      (seq),
        .position (position_reg),
        .match    (match)
    );

    always_comb
    begin
        active    = position_reg < POS_MAX;
        new_start = position_reg + POS_W'(1) - POS_W'(match.len);
        take      = active && match.hit
                    && (!best_valid_reg || (new_start < best_start_reg)
                        || ((new_start == best_start_reg) && (match.len > best_len_reg)));
        cand_valid = best_valid_reg || take;
        cand_start = take ? new_start  : best_start_reg;
        cand_len   = take ? match.len  : best_len_reg;
        cand_code  = take ? match.code : best_code_reg;
        end_ext    = EXT_W'(cand_start) + EXT_W'(cand_len);

        result.found        = cand_valid;
        result.keyword_code = cand_valid ? CODE_W'(cand_code) : '0;
        result.end_offset   = cand_valid ? end_ext[OFFSET_W-1:0] : '0;
    end

    always_comb
    begin
        window_next     = window_reg;
        position_next   = position_reg;
        best_valid_next = best_valid_reg;
        best_start_next = best_start_reg;
        best_len_next   = best_len_reg;
        best_code_next  = best_code_reg;
        if (step && step_last)
        begin
            window_next     = '0;
            position_next   = '0;
            best_valid_next = 1'b0;
            best_start_next = '0;
            best_len_next   = '0;
            best_code_next  = KW_ECDH;
        end
        else if (step && active)
        begin
            window_next     = seq[WIN_DEPTH*8-1:0];
            position_next   = position_reg + POS_W'(1);
            best_valid_next = cand_valid;
            best_start_next = cand_start;
            best_len_next   = cand_len;
            best_code_next  = cand_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            position_reg   <= '0;
            best_valid_reg <= 1'b0;
            best_start_reg <= '0;
            best_len_reg   <= '0;
            best_code_reg  <= KW_ECDH;
        end
        else
        begin
            window_reg     <= window_next;
            position_reg   <= position_next;
            best_valid_reg <= best_valid_next;
            best_start_reg <= best_start_next;
            best_len_reg   <= best_len_next;
            best_code_reg  <= best_code_next;
        end
    end

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        step && step_last |=> (position_reg == '0) && !best_valid_reg && (window_reg == '0))
        else $error("scan state not cleared after last byte");

    a_position_bound: assert property (@(posedge clk) disable iff (!rst_n)
        position_reg <= POS_MAX)
        else $error("byte position beyond bound");

    a_best_len_legal: assert property (@(posedge clk) disable iff (!rst_n)
        best_valid_reg |-> (best_len_reg == 5'd4) || (best_len_reg == 5'd13)
                           || (best_len_reg == 5'd14) || (best_len_reg == 5'd23))
        else $error("best match length is not a keyword length");

    a_best_fits: assert property (@(posedge clk) disable iff (!rst_n)
        best_valid_reg |-> (POS_W + 1)'(best_start_reg) + (POS_W + 1)'(best_len_reg)
                           <= (POS_W + 1)'(position_reg))
        else $error("best match ends beyond bytes scanned");

endmodule

@@ hw/rtl/keyword_signature_scanner.sv @@
`timescale 1ns / 1ps

// channel   signals                                        direction
// scan      scan_valid scan_ready data_byte last_byte       in
// result    result_valid result_ready found keyword_code    out
//           end_offset
//
// one byte per cycle while the input register does not stall; a byte sits in the
// input register, where the ten keyword compares and the best-match update run,
// then its result (last byte only) moves on from there into the result register
// rst_n clears the window, position, best match and both valid flags
// a last byte waits in the input register while an earlier result is not taken

module keyword_signature_scanner #(
    parameter int MAX_BUFFER_BYTES = 65535
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        scan_valid,
    output logic        scan_ready,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        result_valid,
    input  logic        result_ready,
    output logic        found,
    output logic [3:0]  keyword_code,
    output logic [15:0] end_offset
);
    import kss_pkg::*;

    localparam int POS_W = $clog2(MAX_BUFFER_BYTES + 1);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg,  in_byte_next;
    logic         in_last_reg,  in_last_next;
    logic         out_valid_reg, out_valid_next;
    scan_result_t out_reg,       out_next;
    scan_result_t scan_result;
    logic         step;

    assign step       = in_valid_reg && (!in_last_reg || !out_valid_reg || result_ready);
    assign scan_ready = !in_valid_reg || step;

    kss_scan_state #(
        .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES),
        .POS_W            (POS_W)
    ) u_scan_state (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .step_byte (in_byte_reg),
        .step_last (in_last_reg),
        .result    (scan_result)
    );

    always_comb
    begin
        in_valid_next  = in_valid_reg;
        in_byte_next   = in_byte_reg;
        in_last_next   = in_last_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (scan_ready)
        begin
            in_valid_next = scan_valid;
            in_byte_next  = data_byte;
            in_last_next  = last_byte;
        end
        if (step && in_last_reg)
        begin
            out_valid_next = 1'b1;
            out_next       = scan_result;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        in_last_reg <= in_last_next;
        out_reg     <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign found        = out_reg.found;
    assign keyword_code = out_reg.keyword_code;
    assign end_offset   = out_reg.end_offset;

    a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !found |-> (keyword_code == '0) && (end_offset == '0))
        else $error("empty result carries nonzero fields");

    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> keyword_code <= CODE_W'(KW_STOP_RESP))
        else $error("keyword code out of range");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !step |=> in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg))
        else $error("stalled byte lost from input register");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !(step && in_last_reg))
        else $error("pending result overwritten");

endmodule
